@@ sv/pt2d_pkg.sv @@
// shared types, constants and table functions for the 2-d point transform
`default_nettype none

package pt2d_pkg;

  localparam int COORD_BITS          = 16;
  localparam int DEF_TRIG_FRAC_BITS  = 14;
  localparam int MODE_BITS           = 2;
  localparam int SHIFT_BITS          = 16;
  localparam int FACTOR_BITS         = 8;
  localparam int TURN_BITS           = 9;
  localparam int CFG_INDEX_BITS      = 3;
  localparam int CFG_DATA_BITS       = 16;
  localparam int ROM_LAST            = 90;
  localparam int ROM_INDEX_BITS      = 7;

  localparam logic [MODE_BITS-1:0] MODE_TRANSLATE = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_SCALE     = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_ROTATE    = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SHIFT_X      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SHIFT_Y      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FACTOR_X     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FACTOR_Y     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TURN_DEGREES = 3'd4;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef struct packed {
    logic [MODE_BITS-1:0]         mode;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
  } point_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] result_x;
    logic signed [COORD_BITS-1:0] result_y;
    logic                         clipped;
  } result_t;

  // sin(k degrees) in q.30 by taylor series, elaboration only
  function automatic logic [63:0] sine_q30(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd342;
    sum  = (sum >= term) ? sum - term : 64'd0;
    if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    return sum;
  endfunction

  // table entry rounded to frac_bits fraction bits
  function automatic logic [31:0] sine_entry(input int unsigned k, input int unsigned frac_bits);
    logic [63:0] s;
    s = sine_q30(k);
    s = (s + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
    return s[31:0];
  endfunction

  // angle below 360 to {negate, first-quadrant index}
  function automatic logic [ROM_INDEX_BITS:0] quad_map(input logic [TURN_BITS-1:0] a);
    logic [TURN_BITS-1:0] d;
    logic                 neg;
    if (a <= 9'd90) begin
      d   = a;
      neg = 1'b0;
    end else if (a <= 9'd180) begin
      d   = 9'd180 - a;
      neg = 1'b0;
    end else if (a <= 9'd270) begin
      d   = a - 9'd180;
      neg = 1'b1;
    end else begin
      d   = 9'd360 - a;
      neg = 1'b1;
    end
    return {neg, d[ROM_INDEX_BITS-1:0]};
  endfunction

endpackage

`default_nettype wire

@@ sv/point_transform_2d_unit.sv @@
// 2-d point transform: translate, scale or rotate one point per clock with saturation
//
// One point is taken every clock unless the result side stalls, and one result
// comes out for each, in order. A point passes three registers: the input register,
// the product register holding the multiplier outputs, and the result register where
// the sum, the rounding of a rotation and the saturation land. When the result side
// stalls the stages fill one by one, so up to three points are held before in_ready
// drops. A write of turn_degrees looks up sine and cosine at once and keeps them in
// registers, so a rotation uses them from the next point on. The user must write
// registers only while no point is in flight; the block does not enforce this.
`default_nettype none

module point_transform_2d_unit #(
  parameter int TRIG_FRAC_BITS = pt2d_pkg::DEF_TRIG_FRAC_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire pt2d_pkg::point_t                    in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output pt2d_pkg::result_t                        out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [pt2d_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [pt2d_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  import pt2d_pkg::*;

  localparam int TRIG_BITS = TRIG_FRAC_BITS + 2;
  localparam int PW        = COORD_BITS + TRIG_FRAC_BITS + 2;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (TRIG_FRAC_BITS - 1);

  // sine table, first quadrant
  logic [TRIG_FRAC_BITS:0] sine_rom [0:ROM_LAST];

  for (genvar k = 0; k <= ROM_LAST; k++) begin : g_rom
    localparam logic [31:0] ENTRY = sine_entry(k, TRIG_FRAC_BITS);
    assign sine_rom[k] = ENTRY[TRIG_FRAC_BITS:0];
  end

  // configuration
  logic signed [SHIFT_BITS-1:0]  shift_x;
  logic signed [SHIFT_BITS-1:0]  shift_y;
  logic signed [FACTOR_BITS-1:0] factor_x;
  logic signed [FACTOR_BITS-1:0] factor_y;
  logic signed [TRIG_BITS-1:0]   sin_val;
  logic signed [TRIG_BITS-1:0]   cos_val;

  logic [TURN_BITS-1:0]        turn_raw;
  logic [TURN_BITS-1:0]        angle_sin;
  logic [TURN_BITS:0]          angle_cos_wide;
  logic [TURN_BITS-1:0]        angle_cos;
  logic [ROM_INDEX_BITS:0]     map_sin;
  logic [ROM_INDEX_BITS:0]     map_cos;
  logic signed [TRIG_BITS-1:0] mag_sin;
  logic signed [TRIG_BITS-1:0] mag_cos;
  logic signed [TRIG_BITS-1:0] sin_next;
  logic signed [TRIG_BITS-1:0] cos_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    turn_raw       = cfg_data[TURN_BITS-1:0];
    angle_sin      = (turn_raw >= 9'd360) ? turn_raw - 9'd360 : turn_raw;
    angle_cos_wide = {1'b0, angle_sin} + 10'd90;
    angle_cos      = (angle_cos_wide >= 10'd360) ? TURN_BITS'(angle_cos_wide - 10'd360)
                                                 : angle_cos_wide[TURN_BITS-1:0];
    map_sin        = quad_map(angle_sin);
    map_cos        = quad_map(angle_cos);
    mag_sin        = signed'({1'b0, sine_rom[map_sin[ROM_INDEX_BITS-1:0]]});
    mag_cos        = signed'({1'b0, sine_rom[map_cos[ROM_INDEX_BITS-1:0]]});
    sin_next       = map_sin[ROM_INDEX_BITS] ? -mag_sin : mag_sin;
    cos_next       = map_cos[ROM_INDEX_BITS] ? -mag_cos : mag_cos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_x  <= '0;
      shift_y  <= '0;
      factor_x <= FACTOR_BITS'(1);
      factor_y <= FACTOR_BITS'(1);
      sin_val  <= '0;
      cos_val  <= TRIG_BITS'(1) << TRIG_FRAC_BITS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SHIFT_X:      shift_x  <= cfg_data[SHIFT_BITS-1:0];
        REG_SHIFT_Y:      shift_y  <= cfg_data[SHIFT_BITS-1:0];
        REG_FACTOR_X:     factor_x <= cfg_data[FACTOR_BITS-1:0];
        REG_FACTOR_Y:     factor_y <= cfg_data[FACTOR_BITS-1:0];
        REG_TURN_DEGREES: begin
          sin_val <= sin_next;
          cos_val <= cos_next;
        end
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s0_valid;
  logic s1_valid;
  logic s0_ready;
  logic s1_ready;
  logic out_stage_ready;

  assign out_stage_ready = !out_valid || out_ready;
  assign s1_ready        = !s1_valid || out_stage_ready;
  assign s0_ready        = !s0_valid || s1_ready;
  assign in_ready        = s0_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s0_ready) begin
        s0_valid <= in_valid;
      end
      if (s1_ready) begin
        s1_valid <= s0_valid;
      end
      if (out_stage_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

  // input register
  point_t s0_point;

  always_ff @(posedge clk) begin
    if (in_valid && s0_ready) begin
      s0_point <= in_data;
    end
  end

  // products
  logic signed [PW-1:0] px;
  logic signed [PW-1:0] py;
  logic signed [PW-1:0] xa_next;
  logic signed [PW-1:0] xb_next;
  logic signed [PW-1:0] ya_next;
  logic signed [PW-1:0] yb_next;
  logic signed [PW-1:0] s1_xa;
  logic signed [PW-1:0] s1_xb;
  logic signed [PW-1:0] s1_ya;
  logic signed [PW-1:0] s1_yb;
  logic                 s1_rotate;

  always_comb begin
    px      = PW'(s0_point.point_x);
    py      = PW'(s0_point.point_y);
    xa_next = px;
    xb_next = '0;
    ya_next = py;
    yb_next = '0;
    case (s0_point.mode)
      MODE_TRANSLATE: begin
        xa_next = px + PW'(shift_x);
        ya_next = py + PW'(shift_y);
      end
      MODE_SCALE: begin
        xa_next = px * PW'(factor_x);
        ya_next = py * PW'(factor_y);
      end
      MODE_ROTATE: begin
        xa_next = px * PW'(cos_val);
        xb_next = -(py * PW'(sin_val));
        ya_next = px * PW'(sin_val);
        yb_next = py * PW'(cos_val);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s0_valid && s1_ready) begin
      s1_xa     <= xa_next;
      s1_xb     <= xb_next;
      s1_ya     <= ya_next;
      s1_yb     <= yb_next;
      s1_rotate <= (s0_point.mode == MODE_ROTATE);
    end
  end

  // sum, round and saturate
  logic signed [PW-1:0]         sum_x;
  logic signed [PW-1:0]         sum_y;
  logic signed [PW-1:0]         val_x;
  logic signed [PW-1:0]         val_y;
  logic                         clip_x;
  logic                         clip_y;
  logic signed [COORD_BITS-1:0] sat_x;
  logic signed [COORD_BITS-1:0] sat_y;
  result_t                      result_next;

  always_comb begin
    sum_x  = s1_xa + s1_xb + (s1_rotate ? HALF : PW'(0));
    sum_y  = s1_ya + s1_yb + (s1_rotate ? HALF : PW'(0));
    val_x  = s1_rotate ? (sum_x >>> TRIG_FRAC_BITS) : sum_x;
    val_y  = s1_rotate ? (sum_y >>> TRIG_FRAC_BITS) : sum_y;
    clip_x = !(&val_x[PW-1:COORD_BITS-1] || ~|val_x[PW-1:COORD_BITS-1]);
    clip_y = !(&val_y[PW-1:COORD_BITS-1] || ~|val_y[PW-1:COORD_BITS-1]);
    if (clip_x) begin
      sat_x = val_x[PW-1] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
    end else begin
      sat_x = val_x[COORD_BITS-1:0];
    end
    if (clip_y) begin
      sat_y = val_y[PW-1] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
    end else begin
      sat_y = val_y[COORD_BITS-1:0];
    end
    result_next.result_x = sat_x;
    result_next.result_y = sat_y;
    result_next.clipped  = clip_x | clip_y;
  end

  always_ff @(posedge clk) begin
    if (s1_valid && out_stage_ready) begin
      out_data <= result_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/pt2d_checker.sv @@
// port-level checks for the 2-d point transform and their bind
`default_nettype none

module pt2d_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire pt2d_pkg::result_t out_data,
  input wire logic              cfg_valid,
  input wire logic              cfg_ready
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // register writes never stall
  assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

  // input backpressure only comes from a stalled result
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked with free output");

  // a result showing up after an empty output went through an unstalled pipe
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 3))
    else $error("result appeared without a matching input transfer");

endmodule

bind point_transform_2d_unit pt2d_checker u_checker (.*);

`default_nettype wire

@@ bench/pt2d_transform_check.sv @@
// result checker for the 2-d point transform: predicts each transfer and compares outputs
module pt2d_transform_check
  import pt2d_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  point_t                    in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  result_t                   out_data,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output int                        mismatches,
  output int                        pending_results
);

  localparam int FRAC      = DEF_TRIG_FRAC_BITS;

  longint                        sine_tab [0:ROM_LAST];
  logic signed [SHIFT_BITS-1:0]  shift_x  = '0;
  logic signed [SHIFT_BITS-1:0]  shift_y  = '0;
  logic signed [FACTOR_BITS-1:0] factor_x = 8'sd1;
  logic signed [FACTOR_BITS-1:0] factor_y = 8'sd1;
  logic [TURN_BITS-1:0]          turn     = '0;
  result_t                       due_results [$];
  int                            fail_count = 0;

  assign mismatches = fail_count;

  function automatic longint unsigned taylor_sine_q30(input int unsigned deg);
    longint unsigned ang;
    longint unsigned ang2;
    longint unsigned term;
    longint unsigned acc;
    ang  = (64'(deg) * PI_Q30 + 64'd90) / 64'd180;
    ang2 = (ang * ang) >> 30;
    term = ang;
    acc  = ang;
    for (int unsigned n = 1; n <= 9; n++) begin
      term = ((term * ang2) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
      if (n % 2 == 1) begin
        acc = (acc >= term) ? acc - term : 64'd0;
      end else begin
        acc = acc + term;
      end
    end
    if (acc > ONE_Q30) begin
      acc = ONE_Q30;
    end
    return acc;
  endfunction

  initial begin
    for (int k = 0; k <= ROM_LAST; k++) begin
      sine_tab[k] = longint'((taylor_sine_q30(k) + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
    end
  end

  function automatic longint sine_deg(input int unsigned a);
    int unsigned d;
    d = a % 360;
    if (d <= 90) return sine_tab[d];
    if (d <= 180) return sine_tab[180 - d];
    if (d <= 270) return -sine_tab[d - 180];
    return -sine_tab[360 - d];
  endfunction

  // returns {saturated, value}
  function automatic logic [COORD_BITS:0] clamp_coord(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return {1'b1, hi[COORD_BITS-1:0]};
    if (v < lo) return {1'b1, lo[COORD_BITS-1:0]};
    return {1'b0, v[COORD_BITS-1:0]};
  endfunction

  function automatic result_t transform_point(input point_t p);
    longint              x;
    longint              y;
    longint              rx;
    longint              ry;
    longint              s;
    longint              c;
    logic [COORD_BITS:0] cx;
    logic [COORD_BITS:0] cy;
    result_t             r;
    x  = p.point_x;
    y  = p.point_y;
    rx = x;
    ry = y;
    case (p.mode)
      MODE_TRANSLATE: begin
        rx = x + shift_x;
        ry = y + shift_y;
      end
      MODE_SCALE: begin
        rx = x * factor_x;
        ry = y * factor_y;
      end
      MODE_ROTATE: begin
        s  = sine_deg(turn);
        c  = sine_deg(turn % 360 + 90);
        rx = (x * c - y * s + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        ry = (x * s + y * c + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
      end
      default: ;
    endcase
    cx         = clamp_coord(rx);
    cy         = clamp_coord(ry);
    r.result_x = cx[COORD_BITS-1:0];
    r.result_y = cy[COORD_BITS-1:0];
    r.clipped  = cx[COORD_BITS] | cy[COORD_BITS];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: point transform mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      due_results.delete();
      shift_x  = '0;
      shift_y  = '0;
      factor_x = 8'sd1;
      factor_y = 8'sd1;
      turn     = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SHIFT_X:      shift_x  = cfg_data;
          REG_SHIFT_Y:      shift_y  = cfg_data;
          REG_FACTOR_X:     factor_x = cfg_data[FACTOR_BITS-1:0];
          REG_FACTOR_Y:     factor_y = cfg_data[FACTOR_BITS-1:0];
          REG_TURN_DEGREES: turn     = cfg_data[TURN_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result transfer (%0d, %0d) with no point in flight",
                                    got.result_x, got.result_y));
        end else begin
          want = due_results.pop_front();
          if (got.result_x !== want.result_x) begin
            report_mismatch($sformatf("result_x got %0d expected %0d",
                                      got.result_x, want.result_x));
          end
          if (got.result_y !== want.result_y) begin
            report_mismatch($sformatf("result_y got %0d expected %0d",
                                      got.result_y, want.result_y));
          end
          if (got.clipped !== want.clipped) begin
            report_mismatch($sformatf("clipped got %b expected %b", got.clipped, want.clipped));
          end
        end
      end
      if (in_valid && in_ready) begin
        due_results.push_back(transform_point(in_data));
      end
    end
    pending_results <= due_results.size();
  end

endmodule

@@ bench/point_transform_2d_unit_tb.sv @@
// testbench top for the 2-d point transform: stimulus, idling, watchdog and verdict
module point_transform_2d_unit_tb
  import pt2d_pkg::*;
;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 7;
  localparam int PIPE_SETTLE = 6;
  localparam int STALL_LIMIT = 2000;

  localparam logic [MODE_BITS-1:0]      MODE_UNUSED    = 2'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_LO  = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_HI  = 3'd7;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  point_t                    in_data   = '0;
  logic                      out_ready = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
  logic                      in_ready;
  logic                      out_valid;
  result_t                   out_data;
  logic                      cfg_ready;
  int                        mismatches;
  int                        pending_results;
  int                        send_idle_pct = 24;
  int                        take_idle_pct = 45;
  int                        stall_cycles  = 0;

  point_transform_2d_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pt2d_transform_check transform_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending_results (pending_results)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= take_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("point_transform_2d_unit_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic send_point(input logic [MODE_BITS-1:0] mode,
                            input logic [COORD_BITS-1:0] x,
                            input logic [COORD_BITS-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{mode: mode, point_x: x, point_y: y};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // hold off the sender until every point has come back out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  function automatic logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(4))
          0:       return 16'h8000;
          1:       return 16'h7fff;
          2:       return 16'h0000;
          3:       return 16'hffff;
          default: return 16'h0001;
        endcase
      end
      1, 2:    return 16'($urandom_range(511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_phase(input int send_pct, input int take_pct, input int n_items);
    int                       left;
    int                       chunk;
    int                       pick;
    logic [CFG_DATA_BITS-1:0] val;
    logic [MODE_BITS-1:0]     mode;
    send_idle_pct = send_pct;
    take_idle_pct <= take_pct;
    left = n_items;
    while (left > 0) begin
      settle();
      for (int r = REG_SHIFT_X; r <= REG_TURN_DEGREES; r++) begin
        if ($urandom_range(3) == 0) continue;
        val = 16'($urandom);
        if ($urandom_range(2) == 0) begin
          case (r)
            REG_SHIFT_X, REG_SHIFT_Y: val = $urandom_range(1) ? 16'h8000 : 16'h7fff;
            REG_FACTOR_X, REG_FACTOR_Y: begin
              case ($urandom_range(3))
                0:       val[7:0] = 8'h80;
                1:       val[7:0] = 8'h7f;
                2:       val[7:0] = 8'h00;
                default: val[7:0] = 8'hff;
              endcase
            end
            default: begin
              case ($urandom_range(4))
                0:       val[8:0] = 9'd0;
                1:       val[8:0] = 9'd359;
                2:       val[8:0] = 9'd360;
                3:       val[8:0] = 9'd511;
                default: val[8:0] = 9'd180;
              endcase
            end
          endcase
        end
        write_reg(r[CFG_INDEX_BITS-1:0], val);
      end
      if ($urandom_range(7) == 0) begin
        write_reg(3'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), 16'($urandom));
      end
      cfg_valid <= 1'b0;
      chunk = $urandom_range(20, 80);
      if (chunk > left) chunk = left;
      repeat (chunk) begin
        pick = $urandom_range(9);
        if (pick < 3) mode = MODE_TRANSLATE;
        else if (pick < 6) mode = MODE_SCALE;
        else if (pick < 9) mode = MODE_ROTATE;
        else mode = MODE_UNUSED;
        send_point(mode, pick_coord(), pick_coord());
      end
      left -= chunk;
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset values of every register
    send_point(MODE_TRANSLATE, 16'h7fff, 16'h8000);
    send_point(MODE_SCALE, 16'h8000, 16'h7fff);
    send_point(MODE_ROTATE, 16'd1234, 16'hffff);
    send_point(MODE_UNUSED, 16'h8000, 16'h7fff);

    // extreme offsets and factors, quarter turn, writes to unused indexes
    settle();
    write_reg(REG_SHIFT_X, 16'h7fff);
    write_reg(REG_SHIFT_Y, 16'h8000);
    write_reg(REG_FACTOR_X, 16'hff80);
    write_reg(REG_FACTOR_Y, 16'h017f);
    write_reg(REG_TURN_DEGREES, 16'd90);
    write_reg(REG_UNUSED_LO, 16'hffff);
    write_reg(REG_UNUSED_HI, 16'h5a5a);
    cfg_valid <= 1'b0;
    send_point(MODE_TRANSLATE, 16'h7fff, 16'h8000);
    send_point(MODE_TRANSLATE, 16'h8000, 16'h7fff);
    send_point(MODE_SCALE, 16'h8000, 16'h8000);
    send_point(MODE_SCALE, 16'h0001, 16'hffff);
    send_point(MODE_ROTATE, 16'h7fff, 16'h8000);
    send_point(MODE_ROTATE, 16'h8000, 16'h7fff);
    send_point(MODE_UNUSED, 16'h7fff, 16'h8000);

    // 45 degrees with junk in the upper data bits
    settle();
    write_reg(REG_TURN_DEGREES, 16'hfe2d);
    cfg_valid <= 1'b0;
    send_point(MODE_ROTATE, 16'h7fff, 16'h7fff);
    send_point(MODE_ROTATE, 16'h8000, 16'h8000);
    send_point(MODE_ROTATE, 16'd1, 16'd1);
    send_point(MODE_ROTATE, 16'd3, 16'hfff9);

    // angles past a full turn, then 359 and 270 degrees
    settle();
    write_reg(REG_TURN_DEGREES, 16'd400);
    cfg_valid <= 1'b0;
    send_point(MODE_ROTATE, 16'd1000, 16'd2000);
    send_point(MODE_ROTATE, 16'h8000, 16'd0);
    settle();
    write_reg(REG_TURN_DEGREES, 16'd511);
    cfg_valid <= 1'b0;
    send_point(MODE_ROTATE, 16'hffff, 16'h7fff);
    settle();
    write_reg(REG_TURN_DEGREES, 16'd359);
    cfg_valid <= 1'b0;
    send_point(MODE_ROTATE, 16'h7fff, 16'd0);
    settle();
    write_reg(REG_TURN_DEGREES, 16'd270);
    cfg_valid <= 1'b0;
    send_point(MODE_ROTATE, 16'd12345, 16'ha460);

    run_phase(24, 45, 580);
    run_phase(45, 24, 580);
    run_phase(0, 0, 590);

    settle();
    if (mismatches == 0 && pending_results == 0) begin
      $display("point_transform_2d_unit_tb: PASS");
    end else begin
      $display("point_transform_2d_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/pt2d_pkg.sv
sv/point_transform_2d_unit.sv
sv/pt2d_checker.sv
bench/pt2d_transform_check.sv
bench/point_transform_2d_unit_tb.sv
